[rtl/primer_wildcard_locator_macros.svh]
// ----------------------------------------------------------------------------
// primer wildcard locator assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PRIMER_WILDCARD_LOCATOR_MACROS_SVH
`define PRIMER_WILDCARD_LOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define PWL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PWL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PWL_ASSERT_IMP(lbl, ante, cons, msg)
`define PWL_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

[rtl/pwl_pkg.sv]
// ----------------------------------------------------------------------------
// pwl_pkg
// shared types and constants of the primer wildcard locator
// ----------------------------------------------------------------------------
package pwl_pkg;

  localparam int CODE_W     = 4;
  localparam int PRIMER_CAP = 32;
  localparam int IDX_W      = 5;
  localparam int LEN_W      = 6;
  localparam int CFG_W      = 64;
  localparam int CFG_IDX_W  = 2;
  localparam int STATUS_W   = 2;
  localparam int BEGIN_W    = 16;
  localparam int END_W      = 17;
  localparam int MASK_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_CODES_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CODES_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 2'd3;

  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_GAP       = 2'd2;

  localparam logic [CODE_W-1:0] NT_GAP = 4'd15;

  typedef logic [PRIMER_CAP-1:0][CODE_W-1:0] pwl_win_t;

  // per orientation, aligned to the window (newest code at position 0)
  typedef struct packed {
    logic [LEN_W-1:0]                  len;
    logic                              rev;
    logic                              gap;
    logic [1:0][PRIMER_CAP-1:0]        care;
    logic [1:0][PRIMER_CAP-1:0][1:0]   base;
    logic [1:0][PRIMER_CAP-1:0]        wild;
  } pwl_pat_t;

  typedef struct packed {
    logic     valid;
    logic     last;
    logic     upd;
    pwl_win_t win;
  } pwl_stage_t;

endpackage

[rtl/pwl_pattern.sv]
// ----------------------------------------------------------------------------
// pwl_pattern
// configuration registers and the registered search patterns for both
// orientations
// ----------------------------------------------------------------------------
module pwl_pattern import pwl_pkg::*; #(
  parameter int PRIMER_MAX = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  output pwl_pat_t             pat
);

  localparam logic [LEN_W-1:0] LenCap = LEN_W'(PRIMER_MAX);

  logic [CFG_W-1:0] codes_lo_r;
  logic [CFG_W-1:0] codes_hi_r;
  logic [LEN_W-1:0] len_cfg_r;
  logic             rev_cfg_r;

  pwl_pat_t pat_r;
  pwl_pat_t pat_nxt;

  logic [PRIMER_CAP-1:0][CODE_W-1:0] primer;
  logic [LEN_W-1:0]                  len_eff;
  logic [PRIMER_CAP-1:0]             plain_care;
  logic [PRIMER_CAP-1:0]             comp_care;
  logic [PRIMER_CAP-1:0]             plain_wild;
  logic [PRIMER_CAP-1:0]             comp_wild;
  logic [PRIMER_CAP-1:0]             gap_hit;
  logic [PRIMER_CAP-1:0][1:0]        plain_base;
  logic [PRIMER_CAP-1:0][1:0]        comp_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_lo_r <= '0;
      codes_hi_r <= '0;
      len_cfg_r  <= LEN_W'(1);
      rev_cfg_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CODES_LOW:  codes_lo_r <= cfg_wr_data;
        REG_CODES_HIGH: codes_hi_r <= cfg_wr_data;
        REG_LENGTH:     len_cfg_r  <= cfg_wr_data[LEN_W-1:0];
        REG_REVERSE:    rev_cfg_r  <= cfg_wr_data[0];
      endcase
    end
  end

  assign primer = {codes_hi_r, codes_lo_r};

  always_comb begin
    priority if (len_cfg_r == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_cfg_r > LenCap) begin
      len_eff = LenCap;
    end else begin
      len_eff = len_cfg_r;
    end
  end

  // plain care and base read the primer backwards, complement ones read it forwards; wildcard masks the other way
  always_comb begin
    logic [LEN_W-1:0]  ridx;
    logic [CODE_W-1:0] rc;
    logic [CODE_W-1:0] dc;
    logic              in_len;
    for (int j = 0; j < PRIMER_CAP; j++) begin
      in_len        = LEN_W'(j) < len_eff;
      ridx          = len_eff - LEN_W'(j) - LEN_W'(1);
      rc            = primer[ridx[IDX_W-1:0]];
      dc            = primer[j];
      plain_care[j] = in_len && (rc[3:2] == 2'b00);
      plain_base[j] = rc[1:0];
      plain_wild[j] = in_len && (dc[3:2] != 2'b00);
      comp_care[j]  = in_len && (dc[3:2] == 2'b00);
      comp_base[j]  = ~dc[1:0];
      comp_wild[j]  = in_len && (rc[3:2] != 2'b00);
      gap_hit[j]    = in_len && (dc == NT_GAP);
    end
  end

  always_comb begin
    pat_nxt.len     = len_eff;
    pat_nxt.rev     = rev_cfg_r;
    pat_nxt.gap     = |gap_hit;
    pat_nxt.care[0] = rev_cfg_r ? comp_care  : plain_care;
    pat_nxt.care[1] = rev_cfg_r ? plain_care : comp_care;
    pat_nxt.base[0] = rev_cfg_r ? comp_base  : plain_base;
    pat_nxt.base[1] = rev_cfg_r ? plain_base : comp_base;
    pat_nxt.wild[0] = rev_cfg_r ? comp_wild  : plain_wild;
    pat_nxt.wild[1] = rev_cfg_r ? plain_wild : comp_wild;
  end

  always_ff @(posedge clk) begin
    pat_r <= pat_nxt;
  end

  assign pat = pat_r;

endmodule

[rtl/pwl_window.sv]
// ----------------------------------------------------------------------------
// pwl_window
// reference shift window, position counter and the input stage register
// ----------------------------------------------------------------------------
module pwl_window import pwl_pkg::*; #(
  parameter  int PRIMER_MAX = 32,
  parameter  int REF_MAX    = 65536,
  localparam int POS_W      = $clog2(REF_MAX + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_ref_code,
  input  logic              in_ref_last,
  input  logic              s1_go,
  output pwl_stage_t        stage,
  output logic [POS_W-1:0]  stage_pos
);

  logic [PRIMER_MAX-1:0][CODE_W-1:0] win_r;
  logic [PRIMER_MAX-1:0][CODE_W-1:0] win_shift;
  pwl_win_t                          win_pad;
  logic [POS_W-1:0]                  pos_r;
  logic [POS_W-1:0]                  pos_nxt;
  logic                              upd;
  logic                              accept;

  logic             stage_valid_r;
  logic             stage_last_r;
  logic             stage_upd_r;
  pwl_win_t         stage_win_r;
  logic [POS_W-1:0] stage_pos_r;

  for (genvar j = 0; j < PRIMER_MAX; j++) begin : g_shift
    if (j == 0) begin : g_head
      assign win_shift[j] = in_ref_code;
    end else begin : g_tail
      assign win_shift[j] = win_r[j-1];
    end
  end

  always_comb begin
    win_pad = '0;
    for (int j = 0; j < PRIMER_MAX; j++) begin
      win_pad[j] = win_shift[j];
    end
  end

  assign upd      = pos_r < POS_W'(REF_MAX);
  assign pos_nxt  = upd ? pos_r + POS_W'(1) : pos_r;
  assign in_ready = !stage_valid_r || s1_go;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r <= in_ref_last ? '0 : pos_nxt;
      end
      if (accept) begin
        stage_valid_r <= 1'b1;
      end else if (s1_go) begin
        stage_valid_r <= 1'b0;
      end
    end
  end

  // codes past the length limit leave the window alone
  always_ff @(posedge clk) begin
    if (accept) begin
      if (upd) begin
        win_r <= win_shift;
      end
      stage_last_r <= in_ref_last;
      stage_upd_r  <= upd;
      stage_win_r  <= win_pad;
      stage_pos_r  <= pos_nxt;
    end
  end

  assign stage = '{valid: stage_valid_r, last: stage_last_r, upd: stage_upd_r,
                   win: stage_win_r};
  assign stage_pos = stage_pos_r;

endmodule

[rtl/pwl_match.sv]
// ----------------------------------------------------------------------------
// pwl_match
// window compare for both orientations, leftmost match record and the
// result register
// ----------------------------------------------------------------------------
`include "primer_wildcard_locator_macros.svh"

module pwl_match import pwl_pkg::*; #(
  parameter  int REF_MAX = 65536,
  localparam int POS_W   = $clog2(REF_MAX + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  pwl_stage_t            stage,
  input  logic [POS_W-1:0]      stage_pos,
  input  pwl_pat_t              pat,
  output logic                  s1_go,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic                  out_oriented_reversed,
  output logic [BEGIN_W-1:0]    out_match_begin,
  output logic [END_W-1:0]      out_match_end,
  output logic [MASK_W-1:0]     out_wildcard_mask,
  output logic [CFG_W-1:0]      out_matched_ref_low,
  output logic [CFG_W-1:0]      out_matched_ref_high
);

  localparam int BEG_W = (POS_W > BEGIN_W) ? POS_W : BEGIN_W;
  localparam int SUM_W = (POS_W + 1 > END_W) ? POS_W + 1 : END_W;

  logic [1:0]                  found_r;
  logic [1:0]                  found_n;
  logic [1:0][PRIMER_CAP-1:0]  miss;
  logic [1:0]                  match;
  logic [1:0]                  hit;
  logic [1:0][POS_W-1:0]       beg_r;
  logic [1:0][POS_W-1:0]       beg_n;
  logic [1:0][2*CFG_W-1:0]     mwin_r;
  logic [1:0][2*CFG_W-1:0]     mwin_n;
  pwl_win_t                    rwin;
  logic                        reach;
  logic                        out_free;
  logic                        load;

  logic [STATUS_W-1:0] st;
  logic                sel;
  logic [BEG_W-1:0]    beg_ext;
  logic [SUM_W-1:0]    end_sum;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic                out_ori_r;
  logic [BEGIN_W-1:0]  out_begin_r;
  logic [END_W-1:0]    out_end_r;
  logic [MASK_W-1:0]   out_mask_r;
  logic [CFG_W-1:0]    out_lo_r;
  logic [CFG_W-1:0]    out_hi_r;

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      for (int j = 0; j < PRIMER_CAP; j++) begin
        miss[o][j] = pat.care[o][j] && (stage.win[j] != {2'b00, pat.base[o][j]});
      end
      match[o] = ~|miss[o];
    end
  end

  // matched codes in pattern order, oldest first
  always_comb begin
    logic [LEN_W-1:0] ridx;
    for (int i = 0; i < PRIMER_CAP; i++) begin
      ridx    = pat.len - LEN_W'(i) - LEN_W'(1);
      rwin[i] = (LEN_W'(i) < pat.len) ? stage.win[ridx[IDX_W-1:0]] : '0;
    end
  end

  assign reach = stage_pos >= POS_W'(pat.len);

  always_comb begin
    for (int o = 0; o < 2; o++) begin
      hit[o]     = stage.valid && stage.upd && reach && !found_r[o] && match[o];
      found_n[o] = found_r[o] || hit[o];
      beg_n[o]   = hit[o] ? stage_pos - POS_W'(pat.len) : beg_r[o];
      mwin_n[o]  = hit[o] ? rwin : mwin_r[o];
    end
  end

  always_comb begin
    sel = 1'b0;
    priority if (pat.rev && pat.gap) begin
      st = ST_GAP;
    end else if (found_n[0]) begin
      st = ST_FOUND;
    end else if (pat.gap) begin
      st = ST_GAP;
    end else if (found_n[1]) begin
      st  = ST_FOUND;
      sel = 1'b1;
    end else begin
      st = ST_NOT_FOUND;
    end
  end

  assign beg_ext = BEG_W'(beg_n[sel]);
  assign end_sum = SUM_W'(beg_n[sel]) + SUM_W'(pat.len);

  assign out_free = !out_valid_r || out_ready;
  assign s1_go    = stage.valid && (!stage.last || out_free);
  assign load     = s1_go && stage.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_go) begin
        found_r <= stage.last ? '0 : found_n;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      beg_r  <= beg_n;
      mwin_r <= mwin_n;
    end
    if (load) begin
      out_status_r <= st;
      if (st == ST_FOUND) begin
        out_ori_r   <= sel ^ pat.rev;
        out_begin_r <= beg_ext[BEGIN_W-1:0];
        out_end_r   <= end_sum[END_W-1:0];
        out_mask_r  <= pat.wild[sel];
        out_lo_r    <= mwin_n[sel][CFG_W-1:0];
        out_hi_r    <= mwin_n[sel][2*CFG_W-1:CFG_W];
      end else begin
        out_ori_r   <= 1'b0;
        out_begin_r <= '0;
        out_end_r   <= '0;
        out_mask_r  <= '0;
        out_lo_r    <= '0;
        out_hi_r    <= '0;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_oriented_reversed = out_ori_r;
  assign out_match_begin       = out_begin_r;
  assign out_match_end         = out_end_r;
  assign out_wildcard_mask     = out_mask_r;
  assign out_matched_ref_low   = out_lo_r;
  assign out_matched_ref_high  = out_hi_r;

  `PWL_ASSERT_NXT(a_found_cleared, s1_go && stage.last, found_r == 2'b00, "match record not cleared after last item")
  `PWL_ASSERT_NXT(a_found0_held, found_r[0] && !(s1_go && stage.last), found_r[0], "orientation 0 match lost mid-reference")
  `PWL_ASSERT_NXT(a_found1_held, found_r[1] && !(s1_go && stage.last), found_r[1], "orientation 1 match lost mid-reference")
  `PWL_ASSERT_IMP(a_zero_on_miss, out_valid_r && out_status_r != ST_FOUND, out_begin_r == '0 && out_mask_r == '0 && out_lo_r == '0 && out_hi_r == '0, "result fields set without a match")
  `PWL_ASSERT_IMP(a_result_from_last, $rose(out_valid_r), $past(s1_go && stage.last), "result raised without a last item")

endmodule

[rtl/primer_wildcard_locator.sv]
// ----------------------------------------------------------------------------
// primer_wildcard_locator
// streams reference nucleotide codes and reports the leftmost wildcard match
// of the first orientation, else of the second (primer or reverse complement), at the last item
// ----------------------------------------------------------------------------
//  channel  ports                    moves
//  in       in_valid / in_ready      one reference code and its last mark
//  out      out_valid / out_ready    one result per reference, at its last item
//  cfg      cfg_wr_en                primer codes, length, reverse flag
//
//  one item per cycle unless a waiting result stalls the input; an item is compared
//  in the input stage register after it is taken, and its result, if last, is loaded
//  into the output register when it leaves that stage; the window and position counter
//  update on accept, the compare and the leftmost-match record update in the next stage
//  a result waiting in the output register holds the next last item in the
//  input stage, and the input stalls behind it until the result is taken
//  synchronous active-low reset clears config, counters, match flags and valids
// ----------------------------------------------------------------------------
module primer_wildcard_locator import pwl_pkg::*; #(
  parameter int PRIMER_MAX = 32,
  parameter int REF_MAX    = 65536
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [CODE_W-1:0]    in_ref_code,
  input  logic                 in_ref_last,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic                 out_oriented_reversed,
  output logic [BEGIN_W-1:0]   out_match_begin,
  output logic [END_W-1:0]     out_match_end,
  output logic [MASK_W-1:0]    out_wildcard_mask,
  output logic [CFG_W-1:0]     out_matched_ref_low,
  output logic [CFG_W-1:0]     out_matched_ref_high
);

  localparam int POS_W = $clog2(REF_MAX + 1);

  pwl_pat_t         pat;
  pwl_stage_t       stage;
  logic [POS_W-1:0] stage_pos;
  logic             s1_go;

  pwl_pattern #(
    .PRIMER_MAX (PRIMER_MAX)
  ) u_pattern (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .pat         (pat)
  );

  pwl_window #(
    .PRIMER_MAX (PRIMER_MAX),
    .REF_MAX    (REF_MAX)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_ref_code (in_ref_code),
    .in_ref_last (in_ref_last),
    .s1_go       (s1_go),
    .stage       (stage),
    .stage_pos   (stage_pos)
  );

  pwl_match #(
    .REF_MAX (REF_MAX)
  ) u_match (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .stage                 (stage),
    .stage_pos             (stage_pos),
    .pat                   (pat),
    .s1_go                 (s1_go),
    .out_valid             (out_valid),
    .out_ready             (out_ready),
    .out_status            (out_status),
    .out_oriented_reversed (out_oriented_reversed),
    .out_match_begin       (out_match_begin),
    .out_match_end         (out_match_end),
    .out_wildcard_mask     (out_wildcard_mask),
    .out_matched_ref_low   (out_matched_ref_low),
    .out_matched_ref_high  (out_matched_ref_high)
  );

endmodule
